/* hw/rtl/agmu_pkg.sv */
// Shared types, register codes and constants for the adaptive gain momentum update block.
// No dependencies; every other file of the block imports this package.
`default_nettype none
package agmu_pkg;

  localparam int unsigned PARAM_COUNT_DEF = 4096;
  localparam int unsigned CFG_IDX_W       = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LEARN_RATE     = 3'd0,
    REG_SPEED_BONUS    = 3'd1,
    REG_SPEED_PENALTY  = 3'd2,
    REG_GAIN_CEILING   = 3'd3,
    REG_GAIN_FLOOR     = 3'd4,
    REG_AVERAGE_FACTOR = 3'd5,
    REG_MOMENTUM       = 3'd6,
    REG_REG_SCALE      = 3'd7
  } cfg_reg_e;

  localparam logic [30:0] LEARN_RATE_RST     = 31'd655;
  localparam logic [30:0] SPEED_BONUS_RST    = 31'd3277;
  localparam logic [16:0] SPEED_PENALTY_RST  = 17'd62259;
  localparam logic [30:0] GAIN_CEILING_RST   = 31'd655360;
  localparam logic [30:0] GAIN_FLOOR_RST     = 31'd655;
  localparam logic [16:0] AVERAGE_FACTOR_RST = 17'd13107;
  localparam logic [16:0] MOMENTUM_RST       = 17'd0;
  localparam logic [16:0] REG_SCALE_RST      = 17'd65536;

  typedef struct packed {
    logic [11:0]        param_index;
    logic signed [31:0] gradient;
    logic signed [31:0] param_value;
    logic signed [31:0] reg_derivative;
  } in_item_t;

  typedef struct packed {
    logic [11:0]        out_index;
    logic signed [31:0] new_value;
  } out_item_t;

  typedef struct packed {
    logic [31:0]        gain;
    logic signed [31:0] avg;
    logic signed [31:0] dlt;
  } state_word_t;

  localparam state_word_t STATE_RESET = '{gain: 32'd65536, avg: 32'sd0, dlt: 32'sd0};

  function automatic logic signed [31:0] sat32(input logic signed [67:0] x);
    logic signed [31:0] r;
    if (x > 68'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (x < -68'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/adaptive_gain_momentum_update.sv */
// Delta-bar-delta optimiser step with momentum in signed Q16.16, one request per cycle
// unless stalled. Uses agmu_pkg and agmu_state_mem.
//
// The block takes one request per clock while not stalled and returns its result through
// a ten-stage arithmetic pipeline and an output register. A request whose index matches one
// still in the pipeline waits until that earlier request has written its state back. After
// reset a clearing pass writes the initial state to every entry, and no request is taken
// during the pass; configuration writes are taken at any time and must only be made while
// the block is idle.
`default_nettype none
module adaptive_gain_momentum_update #(
  parameter int unsigned PARAM_COUNT = agmu_pkg::PARAM_COUNT_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire agmu_pkg::in_item_t              in_data,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output agmu_pkg::out_item_t                  out_data,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [agmu_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [31:0]                     cfg_data
);
  import agmu_pkg::*;

  localparam int unsigned AW     = (PARAM_COUNT > 1) ? $clog2(PARAM_COUNT) : 1;
  localparam int unsigned NSTAGE = 10;

  typedef struct packed {
    logic [11:0]        idx;
    logic               inr;
    logic signed [31:0] grad;
    logic signed [31:0] value;
    logic signed [31:0] regd;
    logic [31:0]        gain;
    logic signed [31:0] avg;
    logic signed [31:0] dlt;
    logic signed [49:0] prs;
    logic signed [31:0] partial;
    logic               agree;
    logic [48:0]        gp;
    logic signed [49:0] pa;
    logic signed [49:0] pb;
    logic signed [49:0] pm;
    logic [32:0]        gadd;
    logic [31:0]        ngain;
    logic signed [31:0] navg;
    logic signed [34:0] mr;
    logic [62:0]        sprod;
    logic [31:0]        step;
    logic signed [64:0] sp2;
    logic signed [31:0] ndelta;
    logic signed [50:0] tp;
  } pipe_t;

  // Configuration registers
  logic [30:0] learn_rate_r, speed_bonus_r, gain_ceiling_r, gain_floor_r;
  logic [16:0] speed_penalty_r, average_factor_r, momentum_r, reg_scale_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      learn_rate_r     <= LEARN_RATE_RST;
      speed_bonus_r    <= SPEED_BONUS_RST;
      speed_penalty_r  <= SPEED_PENALTY_RST;
      gain_ceiling_r   <= GAIN_CEILING_RST;
      gain_floor_r     <= GAIN_FLOOR_RST;
      average_factor_r <= AVERAGE_FACTOR_RST;
      momentum_r       <= MOMENTUM_RST;
      reg_scale_r      <= REG_SCALE_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_LEARN_RATE:     learn_rate_r     <= cfg_data[30:0];
        REG_SPEED_BONUS:    speed_bonus_r    <= cfg_data[30:0];
        REG_SPEED_PENALTY:  speed_penalty_r  <= cfg_data[16:0];
        REG_GAIN_CEILING:   gain_ceiling_r   <= cfg_data[30:0];
        REG_GAIN_FLOOR:     gain_floor_r     <= cfg_data[30:0];
        REG_AVERAGE_FACTOR: average_factor_r <= cfg_data[16:0];
        REG_MOMENTUM:       momentum_r       <= cfg_data[16:0];
        REG_REG_SCALE:      reg_scale_r      <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  assign cfg_ready = 1'b1;

  // Pipeline control
  pipe_t     st_r   [1:NSTAGE];
  pipe_t     st_nxt [1:NSTAGE];
  logic      v_r    [1:NSTAGE];
  logic      rdy    [1:NSTAGE+1];
  logic      out_valid_r;
  out_item_t out_data_r;
  out_item_t out_data_nxt;
  logic      hazard, accept, clr_busy;
  logic      wr_en;

  logic [AW+11:0] idx_ext;
  logic [AW-1:0]  in_addr;
  logic           in_range;
  state_word_t    rd_data, wr_data;

  assign idx_ext  = {{AW{1'b0}}, in_data.param_index};
  assign in_addr  = idx_ext[AW-1:0];
  assign in_range = idx_ext < (AW+12)'(PARAM_COUNT);

  always_comb begin
    rdy[NSTAGE+1] = !out_valid_r || !out_stall;
    for (int k = NSTAGE; k >= 1; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
  end

  // A request may not read state that an earlier request still has to write back.
  always_comb begin
    hazard = 1'b0;
    for (int k = 1; k <= NSTAGE; k++) begin
      if (v_r[k] && st_r[k].idx == in_data.param_index) begin
        hazard = 1'b1;
      end
    end
  end

  assign in_stall = clr_busy || hazard || !rdy[1];
  assign accept   = in_valid && !in_stall;

  // Datapath temporaries
  logic signed [34:0] rs2;
  logic signed [35:0] diff2;
  logic signed [17:0] wb;
  logic [33:0]        g2;
  logic signed [50:0] asum;
  logic signed [35:0] avr;
  logic [47:0]        stp;
  logic signed [49:0] d8r;
  logic signed [50:0] dsum;
  logic [18:0]        mom_one;
  logic signed [35:0] tr;
  logic signed [36:0] tsum;

  always_comb begin
    st_nxt[1]       = '0;
    st_nxt[1].idx   = in_data.param_index;
    st_nxt[1].inr   = in_range;
    st_nxt[1].grad  = in_data.gradient;
    st_nxt[1].value = in_data.param_value;
    st_nxt[1].regd  = in_data.reg_derivative;

    // Scaled regulariser derivative; state read data joins the request here.
    st_nxt[2]      = st_r[1];
    st_nxt[2].gain = rd_data.gain;
    st_nxt[2].avg  = rd_data.avg;
    st_nxt[2].dlt  = rd_data.dlt;
    st_nxt[2].prs  = $signed({1'b0, reg_scale_r}) * st_r[1].regd;

    // Partial derivative and sign agreement with the stored average
    rs2   = 35'((51'(st_r[2].prs) + 51'sd32768) >>> 16);
    diff2 = 36'(st_r[2].grad) - 36'(rs2);
    st_nxt[3]         = st_r[2];
    st_nxt[3].partial = sat32(68'(diff2));
    st_nxt[3].agree   = (st_r[2].avg > 0 && st_nxt[3].partial > 0) ||
                        (st_r[2].avg < 0 && st_nxt[3].partial < 0);

    // Products for the gain, the average and the momentum term
    wb = 18'sd65536 - $signed({1'b0, average_factor_r});
    st_nxt[4]      = st_r[3];
    st_nxt[4].gp   = 49'(st_r[3].gain) * 49'(speed_penalty_r);
    st_nxt[4].pa   = $signed({1'b0, average_factor_r}) * st_r[3].partial;
    st_nxt[4].pb   = wb * st_r[3].avg;
    st_nxt[4].pm   = $signed({1'b0, momentum_r}) * st_r[3].dlt;
    st_nxt[4].gadd = 33'(st_r[3].gain) + 33'(speed_bonus_r);

    // New gain, new average, rounded momentum term
    g2   = 34'((50'(st_r[4].gp) + 50'd32768) >> 16);
    asum = 51'(st_r[4].pa) + 51'(st_r[4].pb);
    avr  = 36'((52'(asum) + 52'sd32768) >>> 16);
    st_nxt[5] = st_r[4];
    if (st_r[4].agree) begin
      st_nxt[5].ngain = (st_r[4].gadd > 33'(gain_ceiling_r)) ? 32'(gain_ceiling_r)
                                                             : st_r[4].gadd[31:0];
    end else if (g2 < 34'(gain_floor_r)) begin
      st_nxt[5].ngain = 32'(gain_floor_r);
    end else begin
      st_nxt[5].ngain = (g2 > 34'hFFFFFFFF) ? 32'hFFFFFFFF : g2[31:0];
    end
    st_nxt[5].navg = sat32(68'(avr));
    st_nxt[5].mr   = 35'((51'(st_r[4].pm) + 51'sd32768) >>> 16);

    st_nxt[6]       = st_r[5];
    st_nxt[6].sprod = 63'(learn_rate_r) * 63'(st_r[5].ngain);

    stp = 48'((64'(st_r[6].sprod) + 64'd32768) >> 16);
    st_nxt[7]      = st_r[6];
    st_nxt[7].step = (stp > 48'hFFFFFFFF) ? 32'hFFFFFFFF : stp[31:0];

    st_nxt[8]     = st_r[7];
    st_nxt[8].sp2 = $signed({1'b0, st_r[7].step}) * st_r[7].partial;

    d8r  = 50'((66'(st_r[8].sp2) + 66'sd32768) >>> 16);
    dsum = 51'(d8r) + 51'(st_r[8].mr);
    st_nxt[9]        = st_r[8];
    st_nxt[9].ndelta = sat32(68'(dsum));

    mom_one = 19'd65536 + 19'(momentum_r);
    st_nxt[10]    = st_r[9];
    st_nxt[10].tp = $signed(mom_one) * st_r[9].ndelta;

    tr   = 36'((52'(st_r[10].tp) + 52'sd32768) >>> 16);
    tsum = 37'(st_r[10].value) + 37'(tr);
    out_data_nxt.out_index = st_r[10].idx;
    out_data_nxt.new_value = st_r[10].inr ? sat32(68'(tsum)) : st_r[10].value;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 1; k <= NSTAGE; k++) begin
        v_r[k] <= 1'b0;
      end
      out_valid_r <= 1'b0;
    end else begin
      if (rdy[1]) begin
        v_r[1] <= accept;
      end
      for (int k = 2; k <= NSTAGE; k++) begin
        if (rdy[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
      if (rdy[NSTAGE+1]) begin
        out_valid_r <= v_r[NSTAGE];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 1; k <= NSTAGE; k++) begin
      if (rdy[k]) begin
        st_r[k] <= st_nxt[k];
      end
    end
    if (rdy[NSTAGE+1] && v_r[NSTAGE]) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // State write-back as the request leaves the last stage
  logic [AW+11:0] wr_idx_ext;
  assign wr_idx_ext   = {{AW{1'b0}}, st_r[NSTAGE].idx};
  assign wr_en        = v_r[NSTAGE] && rdy[NSTAGE+1] && st_r[NSTAGE].inr;
  assign wr_data.gain = st_r[NSTAGE].ngain;
  assign wr_data.avg  = st_r[NSTAGE].navg;
  assign wr_data.dlt  = st_r[NSTAGE].ndelta;

  agmu_state_mem #(
    .PARAM_COUNT (PARAM_COUNT),
    .AW          (AW)
  ) u_state_mem (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (accept),
    .rd_addr  (in_addr),
    .rd_data  (rd_data),
    .wr_en    (wr_en),
    .wr_addr  (wr_idx_ext[AW-1:0]),
    .wr_data  (wr_data),
    .clr_busy (clr_busy)
  );

  a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy |-> in_stall)
    else $error("request taken during the clearing pass");

  a_writeback_after_clear: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> !clr_busy)
    else $error("state write-back collides with the clearing pass");

  a_last_stage_reaches_output: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[NSTAGE] && rdy[NSTAGE+1]) |=> out_valid_r)
    else $error("result lost between last stage and output register");

  a_accept_enters_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> v_r[1])
    else $error("accepted request did not enter the pipeline");

endmodule
`default_nettype wire

/* hw/rtl/agmu_state_mem.sv */
// Per-parameter state memories (gain, derivative average, previous delta) with one
// write port, one registered read port and a clearing pass after reset. Uses agmu_pkg.
`default_nettype none
module agmu_state_mem #(
  parameter int unsigned PARAM_COUNT = agmu_pkg::PARAM_COUNT_DEF,
  parameter int unsigned AW          = 12
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  rd_en,
  input  wire logic [AW-1:0]         rd_addr,
  output agmu_pkg::state_word_t      rd_data,
  input  wire logic                  wr_en,
  input  wire logic [AW-1:0]         wr_addr,
  input  wire agmu_pkg::state_word_t wr_data,
  output logic                       clr_busy
);
  import agmu_pkg::*;

  state_word_t mem [PARAM_COUNT];
  state_word_t rd_data_r;
  logic [AW-1:0] clr_addr_r;
  logic          clr_busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
      clr_busy_r <= 1'b1;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == AW'(PARAM_COUNT - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      mem[clr_addr_r] <= STATE_RESET;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data  = rd_data_r;
  assign clr_busy = clr_busy_r;

endmodule
`default_nettype wire

/* test/adaptive_gain_momentum_update_test.sv */
// Self-checking testbench for the adaptive gain momentum update block.
// Depends on agmu_pkg and the RTL of adaptive_gain_momentum_update.
// Drives a table of directed requests, then random ones, with predicted results.
module adaptive_gain_momentum_update_test;
  import agmu_pkg::*;

  localparam int unsigned SLOTS = 4096;
  localparam int unsigned WATCHDOG_LIMIT = 20000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_item_t in_data;
  logic out_valid;
  logic out_stall;
  out_item_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0] cfg_data;

  adaptive_gain_momentum_update dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Predictor state and register copies.
  logic [31:0] gain_mem [SLOTS];
  logic signed [31:0] avg_mem [SLOTS];
  logic signed [31:0] delta_mem [SLOTS];
  logic [30:0] r_learn_rate, r_speed_bonus, r_gain_ceiling, r_gain_floor;
  logic [16:0] r_speed_penalty, r_average_factor, r_momentum, r_reg_scale;

  out_item_t pending_results [$];
  int unsigned errors;
  int unsigned idle_cycles;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;

  typedef struct {
    in_item_t req;
    logic has_result;
    logic signed [31:0] result_value;
  } stim_row_t;

  function automatic longint signed round_q16(longint signed x);
    return (x + 64'sd32768) >>> 16;
  endfunction

  function automatic longint signed clamp32(longint signed x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic out_item_t update_slot(in_item_t req);
    out_item_t res;
    longint signed grad, value, regd, partial, avg, old_delta, delta, t;
    longint unsigned gain, step;
    int unsigned i;
    logic agree;
    grad = longint'(req.gradient);
    value = longint'(req.param_value);
    regd = longint'(req.reg_derivative);
    i = req.param_index;
    res.out_index = req.param_index;
    partial = clamp32(grad - round_q16(longint'({1'b0, r_reg_scale}) * regd));
    avg = longint'(avg_mem[i]);
    old_delta = longint'(delta_mem[i]);
    gain = longint'({32'd0, gain_mem[i]});
    agree = (avg > 0 && partial > 0) || (avg < 0 && partial < 0);
    if (agree) begin
      gain = gain + r_speed_bonus;
      if (gain > r_gain_ceiling) gain = r_gain_ceiling;
    end else begin
      gain = (gain * r_speed_penalty + 64'd32768) >> 16;
      if (gain < r_gain_floor) gain = r_gain_floor;
    end
    if (gain > 64'hFFFFFFFF) gain = 64'hFFFFFFFF;
    gain_mem[i] = gain[31:0];
    t = clamp32(round_q16(longint'({1'b0, r_average_factor}) * partial
        + (64'sd65536 - longint'({1'b0, r_average_factor})) * avg));
    avg_mem[i] = t[31:0];
    step = (longint'({1'b0, r_learn_rate}) * gain + 64'd32768) >> 16;
    if (step > 64'hFFFFFFFF) step = 64'hFFFFFFFF;
    delta = clamp32(round_q16(longint'(step) * partial)
        + round_q16(longint'({1'b0, r_momentum}) * old_delta));
    delta_mem[i] = delta[31:0];
    t = clamp32(value + round_q16((64'sd65536 + longint'({1'b0, r_momentum})) * delta));
    res.new_value = t[31:0];
    return res;
  endfunction

  function automatic in_item_t random_request(int unsigned slot_span);
    in_item_t r;
    int unsigned mode;
    mode = $urandom_range(0, 9);
    r.param_index = (slot_span < SLOTS) ? 12'($urandom_range(0, slot_span - 1))
                                        : 12'($urandom);
    r.gradient = (mode < 6) ? 32'($signed($urandom_range(0, 262143)) - 131072) : $urandom;
    r.param_value = (mode == 7) ? $urandom : 32'($signed($urandom_range(0, 1048575)) - 524288);
    case ($urandom_range(0, 3))
      0: r.reg_derivative = '0;
      1: r.reg_derivative = $urandom;
      default: r.reg_derivative = 32'($signed($urandom_range(0, 65535)) - 32768);
    endcase
    return r;
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: stalls at random and checks every accepted result.
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result idx=%0d value=%0d", $time,
                   out_data.out_index, out_data.new_value);
          errors++;
        end else begin
          want = pending_results.pop_front();
          if (out_data.out_index !== want.out_index) begin
            $display("%0t: out_index expected %0d actual %0d", $time,
                     want.out_index, out_data.out_index);
            errors++;
          end
          if (out_data.new_value !== want.new_value) begin
            $display("%0t: new_value expected %0d actual %0d", $time,
                     want.new_value, out_data.new_value);
            errors++;
          end
        end
      end
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // Watchdog on cycles with no accepted request of any kind.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
        || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("** adaptive_gain_momentum_update: FAILED **");
        $finish;
      end
    end
  end

  // Valid stays high after acceptance so that the next request can follow at once;
  // the task drops it itself before a random pause, and the callers before draining.
  task automatic send_request(in_item_t req, out_item_t want);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(want);
  endtask

  task automatic send_predicted(in_item_t req);
    send_request(req, update_slot(req));
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_register(cfg_reg_e which, logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= which;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (which)
      REG_LEARN_RATE:     r_learn_rate = value[30:0];
      REG_SPEED_BONUS:    r_speed_bonus = value[30:0];
      REG_SPEED_PENALTY:  r_speed_penalty = value[16:0];
      REG_GAIN_CEILING:   r_gain_ceiling = value[30:0];
      REG_GAIN_FLOOR:     r_gain_floor = value[30:0];
      REG_AVERAGE_FACTOR: r_average_factor = value[16:0];
      REG_MOMENTUM:       r_momentum = value[16:0];
      default:            r_reg_scale = value[16:0];
    endcase
  endtask

  task automatic load_setting(logic [31:0] rate, logic [31:0] bonus, logic [31:0] penalty,
                              logic [31:0] ceil_v, logic [31:0] floor_v,
                              logic [31:0] avg_f, logic [31:0] mom, logic [31:0] scale);
    write_register(REG_LEARN_RATE, rate);
    write_register(REG_SPEED_BONUS, bonus);
    write_register(REG_SPEED_PENALTY, penalty);
    write_register(REG_GAIN_CEILING, ceil_v);
    write_register(REG_GAIN_FLOOR, floor_v);
    write_register(REG_AVERAGE_FACTOR, avg_f);
    write_register(REG_MOMENTUM, mom);
    write_register(REG_REG_SCALE, scale);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_phase(int unsigned count, int unsigned span, int unsigned s_pct,
                              int unsigned r_pct);
    send_idle_pct = s_pct;
    recv_stall_pct = r_pct;
    repeat (count) send_predicted(random_request(span));
  endtask

  initial begin
    stim_row_t rows [$];
    stim_row_t row;
    out_item_t want;
    int unsigned n;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_LEARN_RATE;
    cfg_data = '0;
    errors = 0;
    idle_cycles = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    for (int i = 0; i < SLOTS; i++) begin
      gain_mem[i] = 32'd65536;
      avg_mem[i] = '0;
      delta_mem[i] = '0;
    end
    r_learn_rate = LEARN_RATE_RST;
    r_speed_bonus = SPEED_BONUS_RST;
    r_speed_penalty = SPEED_PENALTY_RST;
    r_gain_ceiling = GAIN_CEILING_RST;
    r_gain_floor = GAIN_FLOOR_RST;
    r_average_factor = AVERAGE_FACTOR_RST;
    r_momentum = MOMENTUM_RST;
    r_reg_scale = REG_SCALE_RST;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Zero gradient on a fresh slot leaves the value untouched; saturation rows
    // follow from the enormous gradients against the reset learn rate.
    rows.push_back('{'{12'd0, 32'sd0, 32'sd65536, 32'sd0}, 1'b1, 32'sd65536});
    rows.push_back('{'{12'd4095, 32'sd0, 32'sh7FFFFFFF, 32'sd0}, 1'b1, 32'sh7FFFFFFF});
    rows.push_back('{'{12'd4095, 32'sd0, 32'sh80000000, 32'sd0}, 1'b1, 32'sh80000000});
    rows.push_back('{'{12'd1, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sd0}, 1'b0, 32'sd0});
    rows.push_back('{'{12'd1, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sd0}, 1'b0, 32'sd0});
    rows.push_back('{'{12'd2, 32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF}, 1'b0, 32'sd0});
    rows.push_back('{'{12'd2, 32'sh80000000, 32'sd0, 32'sh80000000}, 1'b0, 32'sd0});
    rows.push_back('{'{12'd3, 32'sd65536, 32'sd0, 32'sd0}, 1'b0, 32'sd0});
    rows.push_back('{'{12'd3, 32'sd65536, 32'sd0, 32'sd0}, 1'b0, 32'sd0});
    rows.push_back('{'{12'd3, -32'sd65536, 32'sd0, 32'sd0}, 1'b0, 32'sd0});
    rows.push_back('{'{12'd3, 32'sd0, 32'sd100, 32'sd0}, 1'b0, 32'sd0});
    rows.push_back('{'{12'd4, 32'sd0, 32'sd0, 32'sd131072}, 1'b0, 32'sd0});
    rows.push_back('{'{12'd4, 32'sd0, 32'sd0, -32'sd131072}, 1'b0, 32'sd0});
    rows.push_back('{'{12'd5, 32'sd1, -32'sd1, 32'sd1}, 1'b0, 32'sd0});
    rows.push_back('{'{12'd2048, -32'sd1, 32'sd12345, -32'sd1}, 1'b0, 32'sd0});
    for (int k = 0; k < 4; k++) rows.push_back('{'{12'd6, 32'sd300000, 32'sd0, 32'sd0}, 1'b0, 32'sd0});
    foreach (rows[k]) begin
      row = rows[k];
      want = update_slot(row.req);
      if (row.has_result) want.new_value = row.result_value;
      send_request(row.req, want);
    end
    drain_results();

    // Extremes of every register, then back toward the reset setting.
    load_setting(32'h7FFFFFFF, 32'h7FFFFFFF, 32'd65536, 32'h7FFFFFFF, 32'd0,
                 32'd65536, 32'd65536, 32'd65536);
    for (int k = 0; k < 6; k++) send_predicted('{12'd7, 32'sd65536, 32'sd0, 32'sd0});
    send_predicted('{12'd8, 32'sh80000000, 32'sd0, 32'sh7FFFFFFF});
    random_phase(150, 16, 0, 0);
    drain_results();
    load_setting(32'd0, 32'd0, 32'd0, 32'd0, 32'h7FFFFFFF, 32'd0, 32'd0, 32'd0);
    random_phase(150, 4096, 55, 0);
    drain_results();
    // Values above the stated range are masked to the register width.
    load_setting(32'hFFFFFFFF, 32'd1000, 32'h1FFFF, 32'd1310720, 32'd100,
                 32'h1FFFF, 32'h1FFFF, 32'h1FFFF);
    random_phase(150, 32, 0, 55);
    drain_results();
    load_setting(32'd6554, 32'd3277, 32'd62259, 32'd655360, 32'd655,
                 32'd13107, 32'd58982, 32'd32768);
    random_phase(300, 8, 55, 55);
    random_phase(300, 4096, 6, 6);
    drain_results();
    load_setting(32'd655, 32'd3277, 32'd52429, 32'd655360, 32'd655,
                 32'd6554, 32'd45875, 32'd65536);
    random_phase(350, 64, 0, 0);
    // Sender holds off here until every outstanding result has returned.
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    n = 300;
    random_phase(n, 4, 55, 6);
    drain_results();
    if (errors == 0) begin
      $display("** adaptive_gain_momentum_update: PASSED **");
    end else begin
      $display("** adaptive_gain_momentum_update: FAILED **");
    end
    $finish;
  end
endmodule
